FILE: design/csm_pkg.sv
// Shared types and constants for the contiguous sequence matcher.
// Used by csm_front, csm_queue, csm_back and the top level; depends on nothing.
package csm_pkg;

   localparam int PATTERN_DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH           = 32;
   localparam int CMD_WIDTH             = 2;
   localparam int REQ_DATA_WIDTH        = 40;
   localparam int RSP_DATA_WIDTH        = 8;
   localparam int QUEUE_DEPTH           = 4;

   // Command codes as they arrive on the request stream.
   localparam logic [CMD_WIDTH-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_TEXT   = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 2'd2;

   // Decoded operation kinds carried to the back end.
   typedef enum logic [1:0] {
      KIND_APPEND,
      KIND_TEXT,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic signed [VALUE_WIDTH-1:0]  value;
      logic                           last;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: design/csm_front.sv
// Front end of the matcher: accepts request beats, decodes the command and
// holds the decoded item until the queue takes it. Depends on csm_pkg.
module csm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] command, [33:2] value, [39:34] zero
   input  logic [csm_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  logic                                  req_tlast,
   output logic                                  push_valid,
   output csm_pkg::item_type                     push_item,
   input  csm_pkg::queue_status_type             q_status
);

   logic                  stage_valid_ff;
   logic                  stage_valid_in;
   csm_pkg::item_type     stage_item_ff;
   csm_pkg::item_type     decoded;
   logic                  keep;
   logic                  accept;
   logic [csm_pkg::CMD_WIDTH-1:0] cmd;

   assign cmd = req_tdata[csm_pkg::CMD_WIDTH-1:0];

   // The unused command code is dropped here and never reaches the back end.
   always_comb begin
      decoded.value = req_tdata[csm_pkg::CMD_WIDTH +: csm_pkg::VALUE_WIDTH];
      decoded.last  = req_tlast;
      decoded.kind  = csm_pkg::KIND_TEXT;
      keep          = 1'b1;
      case (cmd)
         csm_pkg::CMD_APPEND: begin
            decoded.kind = csm_pkg::KIND_APPEND;
         end
         csm_pkg::CMD_TEXT: begin
            decoded.kind = csm_pkg::KIND_TEXT;
         end
         csm_pkg::CMD_CLEAR: begin
            decoded.kind = csm_pkg::KIND_CLEAR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push_valid = stage_valid_ff;
   assign push_item  = stage_item_ff;
   assign req_tready = !stage_valid_ff || !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         stage_valid_in = keep;
      end else if (stage_valid_ff && !q_status.full) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_item_ff <= decoded;
      end
   end

endmodule

FILE: design/csm_queue.sv
// Short queue of decoded items between the front and back ends.
// Depends on csm_pkg for the item and status types.
module csm_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  csm_pkg::item_type           push_item,
   input  logic                        pop,
   output csm_pkg::item_type           head_item,
   output csm_pkg::queue_status_type   q_status
);

   localparam int PW = $clog2(csm_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(csm_pkg::QUEUE_DEPTH + 1);

   csm_pkg::item_type  entry_ff [csm_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (count_ff == CW'(csm_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/csm_back.sv
// Back end of the matcher: pattern store, text window, lane compare stage,
// match accumulation and the result register. Depends on csm_pkg.
module csm_back #(
   parameter int PATTERN_DEPTH = csm_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  csm_pkg::item_type                     head_item,
   input  csm_pkg::queue_status_type             q_status,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] found, [1] pattern_truncated, [7:2] zero
   output logic [csm_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata
);

   localparam int LW = $clog2(PATTERN_DEPTH + 1);
   localparam int VW = csm_pkg::VALUE_WIDTH;

   // The pattern is kept newest-first so that lane k always faces window
   // entry k, whatever the pattern length.
   logic signed [VW-1:0]     align_ff  [PATTERN_DEPTH];
   logic signed [VW-1:0]     window_ff [PATTERN_DEPTH];
   logic signed [VW-1:0]     window_in [PATTERN_DEPTH];
   logic [LW-1:0]            pat_len_ff, pat_len_in;
   logic                     pat_closed_ff, pat_closed_in;
   logic                     pat_ovf_ff, pat_ovf_in;
   logic [LW-1:0]            seen_ff, seen_in, seen_next;
   logic [LW-1:0]            len_base;
   logic                     ovf_base;
   logic                     shift_pattern;

   logic [PATTERN_DEPTH-1:0] lane_ok;
   logic                     s2_valid_ff, s2_valid_in;
   logic [PATTERN_DEPTH-1:0] s2_lane_ok_ff;
   logic                     s2_seen_ok_ff;
   logic                     s2_last_ff;
   logic                     s2_ovf_ff;
   logic                     s2_fire;
   logic                     s2_can_load;
   logic                     s2_hit;
   logic                     match_ff, match_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff;
   logic                     rsp_trunc_ff;
   logic                     out_free;
   logic                     out_load;

   logic                     head_valid;
   logic                     is_append, is_text, is_clear;
   logic                     text_pop;

   assign head_valid = !q_status.empty;
   assign is_append  = head_item.kind == csm_pkg::KIND_APPEND;
   assign is_text    = head_item.kind == csm_pkg::KIND_TEXT;
   assign is_clear   = head_item.kind == csm_pkg::KIND_CLEAR;

   // Result side.
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s2_fire     = s2_valid_ff && (!s2_last_ff || out_free);
   assign s2_can_load = !s2_valid_ff || s2_fire;
   assign out_load    = s2_fire && s2_last_ff;
   assign s2_hit      = s2_seen_ok_ff && (&s2_lane_ok_ff);

   // Pattern commands never wait on the compare stage.
   assign pop      = head_valid && (!is_text || s2_can_load);
   assign text_pop = pop && is_text;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(csm_pkg::RSP_DATA_WIDTH - 2){1'b0}}, rsp_trunc_ff, rsp_found_ff};

   // Pattern bookkeeping.
   always_comb begin
      len_base      = pat_closed_ff ? '0 : pat_len_ff;
      ovf_base      = pat_closed_ff ? 1'b0 : pat_ovf_ff;
      pat_len_in    = pat_len_ff;
      pat_ovf_in    = pat_ovf_ff;
      pat_closed_in = pat_closed_ff;
      shift_pattern = 1'b0;
      if (pop && is_append) begin
         pat_closed_in = head_item.last;
         if (len_base < LW'(PATTERN_DEPTH)) begin
            shift_pattern = 1'b1;
            pat_len_in    = len_base + LW'(1);
            pat_ovf_in    = ovf_base;
         end else begin
            pat_len_in    = len_base;
            pat_ovf_in    = 1'b1;
         end
      end else if (pop && is_clear) begin
         pat_len_in    = '0;
         pat_ovf_in    = 1'b0;
         pat_closed_in = 1'b1;
      end else if (text_pop) begin
         pat_closed_in = 1'b1;
      end
   end

   // Window shift and per-lane compare against the pattern as it stands.
   always_comb begin
      window_in[0] = head_item.value;
      for (int k = 1; k < PATTERN_DEPTH; k++) begin
         window_in[k] = window_ff[k-1];
      end
      for (int k = 0; k < PATTERN_DEPTH; k++) begin
         lane_ok[k] = (LW'(k) >= pat_len_ff) || (window_in[k] == align_ff[k]);
      end
      seen_next = (seen_ff < LW'(PATTERN_DEPTH)) ? seen_ff + LW'(1) : seen_ff;
      seen_in   = seen_ff;
      if (text_pop) begin
         seen_in = head_item.last ? '0 : seen_next;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (text_pop) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end
      match_in = match_ff;
      if (s2_fire) begin
         match_in = s2_last_ff ? 1'b0 : (match_ff || s2_hit);
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff    <= '0;
         pat_closed_ff <= 1'b1;
         pat_ovf_ff    <= 1'b0;
         seen_ff       <= '0;
         s2_valid_ff   <= 1'b0;
         match_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pat_len_ff    <= pat_len_in;
         pat_closed_ff <= pat_closed_in;
         pat_ovf_ff    <= pat_ovf_in;
         seen_ff       <= seen_in;
         s2_valid_ff   <= s2_valid_in;
         match_ff      <= match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers; lanes at or beyond the seen count are never trusted.
   always_ff @(posedge clock) begin
      if (shift_pattern) begin
         align_ff[0] <= head_item.value;
         for (int k = 1; k < PATTERN_DEPTH; k++) begin
            align_ff[k] <= align_ff[k-1];
         end
      end
      if (text_pop) begin
         for (int k = 0; k < PATTERN_DEPTH; k++) begin
            window_ff[k] <= window_in[k];
         end
         s2_lane_ok_ff <= lane_ok;
         s2_seen_ok_ff <= seen_next >= pat_len_ff;
         s2_last_ff    <= head_item.last;
         s2_ovf_ff     <= pat_ovf_ff;
      end
      if (out_load) begin
         rsp_found_ff <= match_ff || s2_hit;
         rsp_trunc_ff <= s2_ovf_ff;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      pat_len_ff <= LW'(PATTERN_DEPTH))
      else $error("pattern length beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      pat_ovf_ff |-> (pat_len_ff == LW'(PATTERN_DEPTH)))
      else $error("overflow flagged on a pattern that is not full");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_last_ff && !out_free) |=> (s2_valid_ff && s2_last_ff))
      else $error("last text item left the compare stage while output stalled");

   a_match_cleared: assert property (@(posedge clock) disable iff (reset)
      out_load |=> !match_ff)
      else $error("match flag survived the end of a text");

endmodule

FILE: design/contiguous_sequence_matcher.sv
// Top level of the contiguous sequence matcher: joins front end, queue and
// back end. Depends on csm_pkg, csm_front, csm_queue and csm_back.
//
// Finds whether a loaded pattern of up to PATTERN_DEPTH signed 32-bit values
// occurs as a contiguous run in a streamed text. Each request beat carries a
// command (append pattern element, text element, clear pattern), a value and
// tlast. A text beat with tlast set produces one response beat with found and
// pattern_truncated; no other beat produces a response. While the response
// channel keeps up, the block sustains one beat per clock: every text element
// is checked against all pattern lanes in a single compare stage, and the match
// is folded in the stage after it. With nothing ahead of it, the last text beat
// passes the decode register, the queue, the compare stage and the result
// register before rsp_tvalid rises. A four-entry queue separates decoding from
// execution, so a stalled response channel stops the request side only once
// that queue has filled.
module contiguous_sequence_matcher #(
   parameter int PATTERN_DEPTH = csm_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] command, [33:2] value, [39:34] zero
   input  logic [csm_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] found, [1] pattern_truncated, [7:2] zero
   output logic [csm_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata
);

   logic                        push_valid;
   csm_pkg::item_type           push_item;
   csm_pkg::item_type           head_item;
   csm_pkg::queue_status_type   q_status;
   logic                        pop;

   csm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .q_status   (q_status)
   );

   csm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   csm_back #(
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
